### src/apr_pkg.sv
// Package for the aging page replacement block: sizes, constants and chain types.
`default_nettype none
package apr_pkg;

  localparam int MAX_FRAMES = 8;
  localparam int PAGE_BITS  = 16;
  localparam int AGE_BITS   = 32;
  localparam int CNT_BITS   = 32;
  localparam int CFG_BITS   = 4;
  localparam int IDX_W      = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int FCNT_W     = $clog2(MAX_FRAMES + 1);

  localparam logic [CFG_BITS-1:0] CfgReset = CFG_BITS'(8);
  localparam logic [AGE_BITS-1:0] AgeTop   = {1'b1, {(AGE_BITS-1){1'b0}}};
  localparam logic [CNT_BITS-1:0] CntMax   = '1;

  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [PAGE_BITS-1:0] page_t;
  typedef logic [AGE_BITS-1:0]  age_t;

  // search request travelling down the chain
  typedef struct packed {
    page_t page;
    logic  found;
    idx_t  hit_idx;
    logic  best_vld;
    age_t  best_age;
    idx_t  best_idx;
  } pkt_t;

  // update broadcast to every cell
  typedef struct packed {
    logic  en;
    logic  hit;
    idx_t  slot;
    page_t page;
  } upd_t;

endpackage
`default_nettype wire

### src/apr_cell.sv
// One frame cell: holds valid, tag and age, searches and forwards the request.
`default_nettype none
module apr_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  apr_pkg::idx_t cell_idx_i,
  input  logic          active_i,
  input  logic          pkt_vld_i,
  input  apr_pkg::pkt_t pkt_i,
  output logic          pkt_vld_o,
  output apr_pkg::pkt_t pkt_o,
  input  apr_pkg::upd_t upd_i
);
  import apr_pkg::*;

  logic  valid_q, valid_d;
  page_t tag_q, tag_d;
  age_t  age_q, age_d;
  logic  pkt_vld_q;
  pkt_t  pkt_q, pkt_d;

  always_comb begin
    pkt_d = pkt_i;
    if (active_i) begin
      if (!pkt_i.found && valid_q && (tag_q == pkt_i.page)) begin
        pkt_d.found   = 1'b1;
        pkt_d.hit_idx = cell_idx_i;
      end
      if (!pkt_i.best_vld || (age_q < pkt_i.best_age)) begin
        pkt_d.best_vld = 1'b1;
        pkt_d.best_age = age_q;
        pkt_d.best_idx = cell_idx_i;
      end
    end
  end

  always_comb begin
    valid_d = valid_q;
    tag_d   = tag_q;
    age_d   = age_q;
    if (upd_i.en && active_i) begin
      age_d = age_q >> 1;
      if (upd_i.slot == cell_idx_i) begin
        if (upd_i.hit) begin
          age_d = age_d | AgeTop;
        end else begin
          valid_d = 1'b1;
          tag_d   = upd_i.page;
          age_d   = AgeTop;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= 1'b0;
      tag_q     <= '0;
      age_q     <= '0;
      pkt_vld_q <= 1'b0;
    end else begin
      valid_q   <= valid_d;
      tag_q     <= tag_d;
      age_q     <= age_d;
      pkt_vld_q <= pkt_vld_i;
    end
  end

  // hold the forwarded request until the next one arrives
  always_ff @(posedge clk_i) begin
    if (pkt_vld_i) begin
      pkt_q <= pkt_d;
    end
  end

  assign pkt_vld_o = pkt_vld_q;
  assign pkt_o     = pkt_q;

endmodule
`default_nettype wire

### src/aging_page_replacement_top.sv
// Top level of the aging page replacement block: cell chain, sequencer, totals.
//
//   channel   direction  signals
//   request   in         in_valid_i / in_ready_o, page_number_i
//   result    out        out_valid_o / out_ready_i, hit_o, frame_index_o,
//                        hit_total_o, fault_total_o
//   config    in         cfg_we_i, cfg_wdata_i (frames_in_use)
//
// A request walks the cell chain one cell a cycle; after the last cell the finish step
// ages the active cells and loads the result register.
// A new request is taken only in the idle state, once the last one is finished.
// A waiting result holds the finish step, and the input with it.
// Reset empties every frame, clears both totals and sets frames_in_use to 8.
`default_nettype none
module aging_page_replacement_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] page_number_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        hit_o,
  output logic [2:0]  frame_index_o,
  output logic [31:0] hit_total_o,
  output logic [31:0] fault_total_o
);
  import apr_pkg::*;

  typedef enum logic [1:0] {
    StIdle,
    StSearch,
    StFinish
  } state_e;

  state_e state_q;
  logic [CFG_BITS-1:0] cfg_q;
  logic [FCNT_W-1:0]   n_act;
  logic [MAX_FRAMES-1:0] active;

  logic chain_vld [MAX_FRAMES+1];
  pkt_t chain_pkt [MAX_FRAMES+1];
  upd_t upd;
  pkt_t last;

  logic in_acc, out_free;
  logic [CNT_BITS-1:0] hit_cnt_q, fault_cnt_q;
  logic out_valid_q, hit_q;
  logic [2:0] frame_q;
  idx_t slot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (cfg_q == '0) begin
      n_act = FCNT_W'(1);
    end else if (32'(cfg_q) > MAX_FRAMES) begin
      n_act = FCNT_W'(MAX_FRAMES);
    end else begin
      n_act = FCNT_W'(cfg_q);
    end
  end

  assign in_ready_o = (state_q == StIdle);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    chain_vld[0]          = in_acc;
    chain_pkt[0]          = '0;
    chain_pkt[0].page     = PAGE_BITS'(page_number_i);
  end

  assign last = chain_pkt[MAX_FRAMES];
  assign slot = last.found ? last.hit_idx : last.best_idx;

  always_comb begin
    upd.en   = (state_q == StFinish) && out_free;
    upd.hit  = last.found;
    upd.slot = slot;
    upd.page = last.page;
  end

  for (genvar g = 0; g < MAX_FRAMES; g++) begin : g_cell
    assign active[g] = (32'(n_act) > 32'(g));
    apr_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (IDX_W'(g)),
      .active_i   (active[g]),
      .pkt_vld_i  (chain_vld[g]),
      .pkt_i      (chain_pkt[g]),
      .pkt_vld_o  (chain_vld[g+1]),
      .pkt_o      (chain_pkt[g+1]),
      .upd_i      (upd)
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      hit_cnt_q   <= '0;
      fault_cnt_q <= '0;
      hit_q       <= 1'b0;
      frame_q     <= '0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (in_acc) begin
            state_q <= StSearch;
          end
        end
        StSearch: begin
          if (chain_vld[MAX_FRAMES]) begin
            state_q <= StFinish;
          end
        end
        StFinish: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            hit_q       <= last.found;
            frame_q     <= 3'(slot);
            if (last.found) begin
              if (hit_cnt_q != CntMax) begin
                hit_cnt_q <= hit_cnt_q + 1'b1;
              end
            end else if (fault_cnt_q != CntMax) begin
              fault_cnt_q <= fault_cnt_q + 1'b1;
            end
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign hit_o         = hit_q;
  assign frame_index_o = frame_q;
  assign hit_total_o   = hit_cnt_q;
  assign fault_total_o = fault_cnt_q;

  a_end_in_search : assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain_vld[MAX_FRAMES] |-> (state_q == StSearch))
    else $error("request left the chain outside the search phase");

  a_accept_empty_chain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> !chain_vld[MAX_FRAMES])
    else $error("request taken while the chain still carries one");

  a_hit_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upd.en && upd.hit && (hit_cnt_q != CntMax)) |=>
      (hit_cnt_q == $past(hit_cnt_q) + 1'b1) && out_valid_q && hit_q)
    else $error("hit total did not advance on a hit");

  a_fault_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upd.en && !upd.hit) |=> $stable(hit_cnt_q) && out_valid_q && !hit_q)
    else $error("fault result malformed");

endmodule
`default_nettype wire
